>>> rtl/dd_odo_pkg.sv
`default_nettype none
package dd_odo_pkg;

  localparam int CORDIC_STEPS = 24;

  localparam logic [1:0] REG_SPEED_CONV = 2'd0;
  localparam logic [1:0] REG_TURN_CONV  = 2'd1;
  localparam logic [1:0] REG_TRACK      = 2'd2;
  localparam logic [1:0] REG_INV_TRACK  = 2'd3;

  localparam logic [30:0] SPEED_CONV_RST = 31'd417267;
  localparam logic [30:0] TURN_CONV_RST  = 31'd617644;
  localparam logic [30:0] TRACK_RST      = 31'd655360;
  localparam logic [30:0] INV_TRACK_RST  = 31'd6554;

  // round(3.1415 / 360 * 2^32)
  localparam logic signed [32:0] TURN_SCALE  = 33'sd37479555;
  // round(0.6072529350 * 2^30)
  localparam logic signed [63:0] CORDIC_GAIN = 64'sd652032874;
  localparam logic signed [63:0] ARG_LIMIT   = 64'sh1000_0000_0000_0000;
  localparam logic signed [63:0] NORM_LIMIT  = 64'sh0800_0000_0000_0000;
  localparam logic signed [31:0] QUARTER     = 32'sh4000_0000;

  localparam logic signed [97:0] SAT_MAX = 98'sd2147483647;
  localparam logic signed [97:0] SAT_MIN = -98'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [97:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fff_ffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // atan(2^-i) as a binary angle, 2^32 = two pi.
  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/dd_odo_if.sv
`default_nettype none
interface dd_odo_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] velocity;
  logic signed [31:0] turn_velocity;
  logic signed [31:0] left_revs;
  logic signed [31:0] right_revs;
  modport source (output valid, velocity, turn_velocity, left_revs, right_revs,
                  input ready);
  modport sink (input valid, velocity, turn_velocity, left_revs, right_revs,
                output ready);
endinterface

interface dd_odo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_rpm;
  logic signed [31:0] right_rpm;
  logic signed [31:0] x_position;
  logic signed [31:0] y_position;
  logic signed [31:0] heading;
  modport source (output valid, left_rpm, right_rpm, x_position, y_position, heading,
                  input ready);
  modport sink (input valid, left_rpm, right_rpm, x_position, y_position, heading,
                output ready);
endinterface
`default_nettype wire

>>> rtl/diff_drive_odometry.sv
`default_nettype none
// Differential-drive speed split and dead-reckoning odometry, Q16.16.
// in_ch carries one control tick (velocity, turn rate, cumulative wheel
// revolutions); out_ch returns one result per tick: left and right rpm
// commands and the updated pose (x, y, binary-angle heading).
// cfg_we/cfg_index/cfg_data write the four gain registers; write them only
// while no tick is in flight.
// One 33x33 multiplier and one CORDIC shift-add stage are shared under a
// sequencer. Before the 24-step atan vectoring the vector is doubled
// between 0 and 43 times to normalize it; 24 sin/cos CORDIC steps follow
// the heading update.
// in_ch.ready is high only while the sequencer is idle, one tick at a time.
// The result sits in an output register, so the next tick is taken while it
// waits; if the receiver still stalls when the next result is done, the
// sequencer holds until the output register is free.
// Synchronous reset restores the register defaults and clears the pose and
// the stored wheel counts.
module diff_drive_odometry (
  input  wire                 clk,
  input  wire                 rst_n,
  dd_odo_in_if.sink           in_ch,
  dd_odo_out_if.source        out_ch,
  input  wire                 cfg_we,
  input  wire  [1:0]          cfg_index,
  input  wire  [30:0]         cfg_data
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_TURN   = 5'd1;
  localparam logic [4:0] ST_HALF   = 5'd2;
  localparam logic [4:0] ST_RR_LO  = 5'd3;
  localparam logic [4:0] ST_RR_HI  = 5'd4;
  localparam logic [4:0] ST_RL_LO  = 5'd5;
  localparam logic [4:0] ST_RL_HI  = 5'd6;
  localparam logic [4:0] ST_DIST   = 5'd7;
  localparam logic [4:0] ST_MM     = 5'd8;
  localparam logic [4:0] ST_ARG_LO = 5'd9;
  localparam logic [4:0] ST_ARG_HI = 5'd10;
  localparam logic [4:0] ST_NORM   = 5'd11;
  localparam logic [4:0] ST_ATAN   = 5'd12;
  localparam logic [4:0] ST_HEAD   = 5'd13;
  localparam logic [4:0] ST_SETUP  = 5'd14;
  localparam logic [4:0] ST_ROT    = 5'd15;
  localparam logic [4:0] ST_SC     = 5'd16;
  localparam logic [4:0] ST_PX_LO  = 5'd17;
  localparam logic [4:0] ST_PX_HI  = 5'd18;
  localparam logic [4:0] ST_PY_LO  = 5'd19;
  localparam logic [4:0] ST_PY_HI  = 5'd20;
  localparam logic [4:0] ST_OUT    = 5'd21;

  localparam logic [4:0] LAST_STEP = 5'(dd_odo_pkg::CORDIC_STEPS - 1);

  logic [4:0]         state_r;
  logic               ph_r;
  logic [30:0]        speed_conv_r, turn_conv_r, track_r, inv_track_r;
  logic [31:0]        last_left_r, last_right_r;
  logic signed [31:0] pose_x_r, pose_y_r;
  logic [31:0]        pose_heading_r;

  logic signed [31:0] vel_r, tv_r;
  logic signed [32:0] dsum_r, ddiff_r;
  logic signed [25:0] turn_r;
  logic signed [40:0] vr_r, vl_r;
  logic signed [48:0] dist_r;
  logic signed [63:0] m_r;
  logic signed [97:0] acc_r;
  logic signed [65:0] prod_r;
  logic signed [63:0] x_r, y_r;
  logic signed [31:0] z_r;
  logic [4:0]         it_r;
  logic               flip_r;
  logic signed [32:0] s_r, c_r;
  logic signed [31:0] rpm_l_r, rpm_r_r;

  logic               out_valid_r;
  logic signed [31:0] out_left_r, out_right_r, out_x_r, out_y_r, out_head_r;

  logic signed [32:0] mul_a, mul_b;
  logic               is_mul;
  logic signed [97:0] hi_sum;
  logic signed [97:0] arg_w;
  logic signed [63:0] xs, ys;
  logic signed [31:0] tab;
  logic signed [31:0] dl_w, dr_w;
  logic signed [39:0] half_w;
  logic signed [31:0] head_s;
  logic               far_w;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.left_rpm   = out_left_r;
  assign out_ch.right_rpm  = out_right_r;
  assign out_ch.x_position = out_x_r;
  assign out_ch.y_position = out_y_r;
  assign out_ch.heading    = out_head_r;

  assign dl_w   = in_ch.left_revs - $signed(last_left_r);
  assign dr_w   = in_ch.right_revs - $signed(last_right_r);
  assign half_w = prod_r[56:17];
  assign hi_sum = acc_r + (98'(prod_r) <<< 32);
  assign arg_w  = hi_sum >>> 32;
  assign xs     = x_r >>> it_r;
  assign ys     = y_r >>> it_r;
  assign tab    = $signed({2'b00, dd_odo_pkg::atan_entry(it_r)});
  assign head_s = $signed(pose_heading_r);
  assign far_w  = (head_s > dd_odo_pkg::QUARTER) || (head_s < -dd_odo_pkg::QUARTER);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    is_mul = 1'b1;
    case (state_r)
      ST_TURN: begin
        mul_a = 33'(tv_r);
        mul_b = dd_odo_pkg::TURN_SCALE;
      end
      ST_HALF: begin
        mul_a = $signed({2'b00, track_r});
        mul_b = 33'(turn_r);
      end
      ST_RR_LO: begin
        mul_a = $signed({1'b0, vr_r[31:0]});
        mul_b = $signed({2'b00, speed_conv_r});
      end
      ST_RR_HI: begin
        mul_a = 33'($signed(vr_r[40:32]));
        mul_b = $signed({2'b00, speed_conv_r});
      end
      ST_RL_LO: begin
        mul_a = $signed({1'b0, vl_r[31:0]});
        mul_b = $signed({2'b00, speed_conv_r});
      end
      ST_RL_HI: begin
        mul_a = 33'($signed(vl_r[40:32]));
        mul_b = $signed({2'b00, speed_conv_r});
      end
      ST_DIST: begin
        mul_a = dsum_r;
        mul_b = $signed({2'b00, turn_conv_r});
      end
      ST_MM: begin
        mul_a = ddiff_r;
        mul_b = $signed({2'b00, turn_conv_r});
      end
      ST_ARG_LO: begin
        mul_a = $signed({1'b0, m_r[31:0]});
        mul_b = $signed({2'b00, inv_track_r});
      end
      ST_ARG_HI: begin
        mul_a = 33'($signed(m_r[63:32]));
        mul_b = $signed({2'b00, inv_track_r});
      end
      ST_PX_LO: begin
        mul_a = $signed({1'b0, dist_r[31:0]});
        mul_b = s_r;
      end
      ST_PX_HI: begin
        mul_a = 33'($signed(dist_r[48:32]));
        mul_b = s_r;
      end
      ST_PY_LO: begin
        mul_a = $signed({1'b0, dist_r[31:0]});
        mul_b = c_r;
      end
      ST_PY_HI: begin
        mul_a = 33'($signed(dist_r[48:32]));
        mul_b = c_r;
      end
      default: begin
        is_mul = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      ph_r           <= 1'b0;
      out_valid_r    <= 1'b0;
      speed_conv_r   <= dd_odo_pkg::SPEED_CONV_RST;
      turn_conv_r    <= dd_odo_pkg::TURN_CONV_RST;
      track_r        <= dd_odo_pkg::TRACK_RST;
      inv_track_r    <= dd_odo_pkg::INV_TRACK_RST;
      last_left_r    <= '0;
      last_right_r   <= '0;
      pose_x_r       <= '0;
      pose_y_r       <= '0;
      pose_heading_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dd_odo_pkg::REG_SPEED_CONV: speed_conv_r <= cfg_data;
          dd_odo_pkg::REG_TURN_CONV:  turn_conv_r  <= cfg_data;
          dd_odo_pkg::REG_TRACK:      track_r      <= cfg_data;
          dd_odo_pkg::REG_INV_TRACK:  inv_track_r  <= cfg_data;
          default: ;
        endcase
      end

      // In ST_OUT the output register is handled by the state itself.
      if (out_ch.ready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end

      // Each multiply state first loads the product register and then, with
      // ph_r set, uses it.
      ph_r <= is_mul & ~ph_r;

      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            vel_r        <= in_ch.velocity;
            tv_r         <= in_ch.turn_velocity;
            dsum_r       <= 33'(dl_w) + 33'(dr_w);
            ddiff_r      <= 33'(dl_w) - 33'(dr_w);
            last_left_r  <= in_ch.left_revs;
            last_right_r <= in_ch.right_revs;
            state_r      <= ST_TURN;
          end
        end
        ST_TURN: begin
          if (ph_r) begin
            turn_r  <= prod_r[57:32];
            state_r <= ST_HALF;
          end
        end
        ST_HALF: begin
          if (ph_r) begin
            vr_r    <= 41'(vel_r) + 41'(half_w);
            vl_r    <= 41'(vel_r) - 41'(half_w);
            state_r <= ST_RR_LO;
          end
        end
        ST_RR_LO: begin
          if (ph_r) begin
            acc_r   <= 98'(prod_r);
            state_r <= ST_RR_HI;
          end
        end
        ST_RR_HI: begin
          if (ph_r) begin
            rpm_r_r <= dd_odo_pkg::sat32(hi_sum >>> 16);
            state_r <= ST_RL_LO;
          end
        end
        ST_RL_LO: begin
          if (ph_r) begin
            acc_r   <= 98'(prod_r);
            state_r <= ST_RL_HI;
          end
        end
        ST_RL_HI: begin
          if (ph_r) begin
            rpm_l_r <= dd_odo_pkg::sat32(hi_sum >>> 16);
            state_r <= ST_DIST;
          end
        end
        ST_DIST: begin
          if (ph_r) begin
            dist_r  <= prod_r[65:17];
            state_r <= ST_MM;
          end
        end
        ST_MM: begin
          if (ph_r) begin
            m_r     <= prod_r[63:0];
            state_r <= ST_ARG_LO;
          end
        end
        ST_ARG_LO: begin
          if (ph_r) begin
            acc_r   <= 98'(prod_r);
            state_r <= ST_ARG_HI;
          end
        end
        ST_ARG_HI: begin
          if (ph_r) begin
            if (arg_w > 98'(dd_odo_pkg::ARG_LIMIT)) begin
              y_r <= dd_odo_pkg::ARG_LIMIT;
            end else if (arg_w < -98'(dd_odo_pkg::ARG_LIMIT)) begin
              y_r <= -dd_odo_pkg::ARG_LIMIT;
            end else begin
              y_r <= arg_w[63:0];
            end
            x_r     <= 64'sd65536;
            z_r     <= '0;
            state_r <= ST_NORM;
          end
        end
        ST_NORM: begin
          // Scale the vector up until either component reaches 2^59.
          if ((x_r < dd_odo_pkg::NORM_LIMIT) && (x_r > -dd_odo_pkg::NORM_LIMIT) &&
              (y_r < dd_odo_pkg::NORM_LIMIT) && (y_r > -dd_odo_pkg::NORM_LIMIT)) begin
            x_r <= x_r <<< 1;
            y_r <= y_r <<< 1;
          end else begin
            it_r    <= '0;
            state_r <= ST_ATAN;
          end
        end
        ST_ATAN: begin
          if (!y_r[63]) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + tab;
          end else begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - tab;
          end
          it_r <= it_r + 5'd1;
          if (it_r == LAST_STEP) begin
            state_r <= ST_HEAD;
          end
        end
        ST_HEAD: begin
          pose_heading_r <= pose_heading_r + z_r;
          state_r        <= ST_SETUP;
        end
        ST_SETUP: begin
          // Angles beyond a quarter turn are rotated by a half turn and the
          // result negated afterwards.
          z_r     <= far_w ? $signed({~pose_heading_r[31], pose_heading_r[30:0]}) : head_s;
          flip_r  <= far_w;
          x_r     <= dd_odo_pkg::CORDIC_GAIN;
          y_r     <= '0;
          it_r    <= '0;
          state_r <= ST_ROT;
        end
        ST_ROT: begin
          if (!z_r[31]) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - tab;
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + tab;
          end
          it_r <= it_r + 5'd1;
          if (it_r == LAST_STEP) begin
            state_r <= ST_SC;
          end
        end
        ST_SC: begin
          s_r     <= flip_r ? -$signed(y_r[32:0]) : $signed(y_r[32:0]);
          c_r     <= flip_r ? -$signed(x_r[32:0]) : $signed(x_r[32:0]);
          state_r <= ST_PX_LO;
        end
        ST_PX_LO: begin
          if (ph_r) begin
            acc_r   <= 98'(prod_r);
            state_r <= ST_PX_HI;
          end
        end
        ST_PX_HI: begin
          if (ph_r) begin
            pose_x_r <= dd_odo_pkg::sat32((hi_sum >>> 30) + 98'(pose_x_r));
            state_r  <= ST_PY_LO;
          end
        end
        ST_PY_LO: begin
          if (ph_r) begin
            acc_r   <= 98'(prod_r);
            state_r <= ST_PY_HI;
          end
        end
        ST_PY_HI: begin
          if (ph_r) begin
            pose_y_r <= dd_odo_pkg::sat32((hi_sum >>> 30) + 98'(pose_y_r));
            state_r  <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_left_r  <= rpm_l_r;
            out_right_r <= rpm_r_r;
            out_x_r     <= pose_x_r;
            out_y_r     <= pose_y_r;
            out_head_r  <= head_s;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
